FILE: src/dosp_pkg.sv
package dosp_pkg;

   // Magic cookie that opens every DHCPv4 options area.
   localparam logic [7:0] CookieByte0 = 8'h63;
   localparam logic [7:0] CookieByte1 = 8'h82;
   localparam logic [7:0] CookieByte2 = 8'h53;
   localparam logic [7:0] CookieByte3 = 8'h63;

   // Option codes with a meaning of their own.
   localparam logic [7:0] OptPad     = 8'd0;
   localparam logic [7:0] OptEnd     = 8'd255;
   localparam logic [7:0] OptMsgType = 8'd53;

   // Configuration register map.
   localparam int unsigned CsrAddrWidth = 3;
   localparam logic [0:0] RegMaxOptions = 1'b0;
   localparam logic [7:0] MaxOptionsReset = 8'd16;

   typedef enum logic [2:0] {
      ROLE_COOKIE = 3'd0,
      ROLE_PAD    = 3'd1,
      ROLE_CODE   = 3'd2,
      ROLE_LENGTH = 3'd3,
      ROLE_DATA   = 3'd4,
      ROLE_END    = 3'd5,
      ROLE_IGNORE = 3'd6
   } role_type;

   typedef struct packed {
      logic [7:0] byte_value;
      role_type   byte_role;
      logic [7:0] option_code;
      logic [7:0] option_length;
      logic [7:0] data_offset;
      logic       option_kept;
      logic [7:0] options_found;
      logic [7:0] message_type;
      logic       message_type_valid;
      logic       region_done;
      logic       status;
   } result_type;

   function automatic logic [7:0] cookie_byte(input logic [1:0] pos);
      logic [7:0] value;
      unique case (pos)
         2'd0: value = CookieByte0;
         2'd1: value = CookieByte1;
         2'd2: value = CookieByte2;
         2'd3: value = CookieByte3;
         default: value = CookieByte0;
      endcase
      return value;
   endfunction

endpackage

FILE: src/dosp_if.sv
interface dosp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dosp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic [2:0] byte_role;
   logic [7:0] option_code;
   logic [7:0] option_length;
   logic [7:0] data_offset;
   logic       option_kept;
   logic [7:0] options_found;
   logic [7:0] message_type;
   logic       message_type_valid;
   logic       region_done;
   logic       status;

   modport source (
      output valid, input ready,
      output byte_value, output byte_role, output option_code, output option_length,
      output data_offset, output option_kept, output options_found,
      output message_type, output message_type_valid, output region_done, output status
   );
   modport sink (
      input valid, output ready,
      input byte_value, input byte_role, input option_code, input option_length,
      input data_offset, input option_kept, input options_found,
      input message_type, input message_type_valid, input region_done, input status
   );
endinterface

FILE: src/dosp_csr.sv
module dosp_csr
   import dosp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready,
   output logic [7:0]              max_options
);

   logic [7:0] max_options_ff;
   logic [7:0] max_options_in;
   logic       sel_max_options;

   // Registers sit on 4-byte boundaries, so the low address bits are ignored.
   assign sel_max_options = (paddr[CsrAddrWidth-1] == RegMaxOptions);

   always_comb begin
      max_options_in = max_options_ff;
      if (psel && penable && pwrite && sel_max_options) begin
         max_options_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_options_ff <= MaxOptionsReset;
      end else begin
         max_options_ff <= max_options_in;
      end
   end

   assign prdata      = sel_max_options ? {24'd0, max_options_ff} : 32'd0;
   assign pready      = 1'b1;
   assign max_options = max_options_ff;

endmodule

FILE: src/dosp_step.sv
module dosp_step
   import dosp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic [7:0] max_options,
   output result_type result
);

   typedef enum logic [2:0] {
      PH_COOKIE = 3'd0,
      PH_CODE   = 3'd1,
      PH_LENGTH = 3'd2,
      PH_DATA   = 3'd3,
      PH_AFTER  = 3'd4,
      PH_ERROR  = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [1:0] cookie_pos_ff, cookie_pos_in;
   logic [7:0] code_ff, code_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] data_pos_ff, data_pos_in;
   logic       kept_ff, kept_in;
   logic [7:0] kept_count_ff, kept_count_in;
   logic [7:0] type_value_ff, type_value_in;
   logic       type_seen_ff, type_seen_in;

   role_type   role;
   logic [7:0] out_code;
   logic [7:0] out_len;
   logic [7:0] out_off;
   logic       out_kept;
   logic       err;
   logic       finish;
   logic [7:0] data_pos_inc;

   assign data_pos_inc = data_pos_ff + 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      cookie_pos_in = cookie_pos_ff;
      code_in       = code_ff;
      length_in     = length_ff;
      data_pos_in   = data_pos_ff;
      kept_in       = kept_ff;
      kept_count_in = kept_count_ff;
      type_value_in = type_value_ff;
      type_seen_in  = type_seen_ff;
      role          = ROLE_IGNORE;
      out_code      = 8'd0;
      out_len       = 8'd0;
      out_off       = 8'd0;
      out_kept      = 1'b0;
      err           = 1'b0;
      finish        = 1'b0;

      unique case (phase_ff)
         PH_COOKIE: begin
            role = ROLE_COOKIE;
            if (data_byte != cookie_byte(cookie_pos_ff)) begin
               phase_in = PH_ERROR;
               err      = 1'b1;
            end else if (cookie_pos_ff == 2'd3) begin
               phase_in      = PH_CODE;
               cookie_pos_in = 2'd0;
            end else begin
               // A region that ends inside the cookie is short.
               cookie_pos_in = cookie_pos_ff + 2'd1;
               err           = 1'b1;
            end
         end
         PH_CODE: begin
            priority if (data_byte == OptPad) begin
               role = ROLE_PAD;
            end else if (data_byte == OptEnd) begin
               role     = ROLE_END;
               out_code = OptEnd;
               phase_in = PH_AFTER;
            end else begin
               role        = ROLE_CODE;
               code_in     = data_byte;
               length_in   = 8'd0;
               data_pos_in = 8'd0;
               kept_in     = (kept_count_ff < max_options);
               out_code    = data_byte;
               out_kept    = kept_in;
               phase_in    = PH_LENGTH;
               err         = 1'b1;
            end
         end
         PH_LENGTH: begin
            role        = ROLE_LENGTH;
            length_in   = data_byte;
            data_pos_in = 8'd0;
            out_code    = code_ff;
            out_len     = data_byte;
            out_kept    = kept_ff;
            if (data_byte == 8'd0) begin
               finish = 1'b1;
            end else begin
               phase_in = PH_DATA;
               err      = 1'b1;
            end
         end
         PH_DATA: begin
            role     = ROLE_DATA;
            out_code = code_ff;
            out_len  = length_ff;
            out_off  = data_pos_ff;
            out_kept = kept_ff;
            if (kept_ff && code_ff == OptMsgType && data_pos_ff == 8'd0 && !type_seen_ff) begin
               type_value_in = data_byte;
            end
            if (data_pos_inc >= length_ff) begin
               finish = 1'b1;
            end else begin
               data_pos_in = data_pos_inc;
               err         = 1'b1;
            end
         end
         PH_AFTER: begin
            role = ROLE_IGNORE;
         end
         default: begin
            role = ROLE_IGNORE;
            err  = 1'b1;
         end
      endcase

      // Option complete: count it if kept, and latch the message type.
      if (finish) begin
         if (kept_ff) begin
            kept_count_in = kept_count_ff + 8'd1;
            if (code_ff == OptMsgType && length_in != 8'd0 && !type_seen_ff) begin
               type_seen_in = 1'b1;
            end
         end
         phase_in = PH_CODE;
      end

      result.byte_value         = data_byte;
      result.byte_role          = role;
      result.option_code        = out_code;
      result.option_length      = out_len;
      result.data_offset        = out_off;
      result.option_kept        = out_kept;
      result.options_found      = kept_count_in;
      result.message_type       = type_seen_in ? type_value_in : 8'd0;
      result.message_type_valid = type_seen_in;
      result.region_done        = last_byte;
      result.status             = last_byte & err;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last_byte)) begin
         phase_ff      <= PH_COOKIE;
         cookie_pos_ff <= 2'd0;
         code_ff       <= 8'd0;
         length_ff     <= 8'd0;
         data_pos_ff   <= 8'd0;
         kept_ff       <= 1'b0;
         kept_count_ff <= 8'd0;
         type_value_ff <= 8'd0;
         type_seen_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         cookie_pos_ff <= cookie_pos_in;
         code_ff       <= code_in;
         length_ff     <= length_in;
         data_pos_ff   <= data_pos_in;
         kept_ff       <= kept_in;
         kept_count_ff <= kept_count_in;
         type_value_ff <= type_value_in;
         type_seen_ff  <= type_seen_in;
      end
   end

`ifndef SYNTHESIS
   a_region_restart: assert property (@(posedge clock) disable iff (reset)
      advance && last_byte |=> phase_ff == PH_COOKIE && kept_count_ff == 8'd0 && !type_seen_ff)
      else $error("parser state not cleared after the last word of a region");

   a_hold_without_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(kept_count_ff) && $stable(data_pos_ff))
      else $error("parser state moved without a word");

   a_type_sticky: assert property (@(posedge clock) disable iff (reset)
      type_seen_ff && advance && !last_byte |=> type_seen_ff && $stable(type_value_ff))
      else $error("captured message type changed within a region");
`endif

endmodule

FILE: src/dhcp_option_stream_parser_core.sv
// DHCPv4 options-area parser. Bytes of the options area enter one word at a time on req,
// with last_byte set on the final byte of the region; every word gives exactly one result
// word on rsp that carries the byte, its role (cookie, pad, code, length, data, end
// marker or ignored), the option code, declared length, data offset and kept flag,
// the running count of complete kept options, the captured message type (option 53)
// and, on the last byte, a status that flags a short region, a bad cookie or a cut-off
// option. The block takes one word per clock while rsp.ready allows: a word waits in the
// input register, the parser state update for it runs as it leaves that register, and its
// result is captured in the output register and offered from there on rsp, so throughput
// is limited only by rsp.ready. All parse state returns to its start after each last
// byte. The max_options register (byte address 0, reset 16) sets how many options per
// region are kept and counted; write it only while no word is in flight.
module dhcp_option_stream_parser_core
   import dosp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   dosp_req_if.sink                req,
   dosp_rsp_if.source              rsp,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic [7:0] max_options;

   // Input register: holds one accepted word until the parser consumes it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // Output register: holds a finished result until the sink takes it.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;

   result_type step_result;
   logic       move;
   logic       req_take;

   dosp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .max_options (max_options)
   );

   // The word in the input register advances whenever the output register is empty
   // or is being emptied in this same cycle.
   assign move      = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || move;
   assign req_take  = req.valid && req.ready;

   dosp_step u_step (
      .clock       (clock),
      .reset       (reset),
      .advance     (move),
      .data_byte   (in_byte_ff),
      .last_byte   (in_last_ff),
      .max_options (max_options),
      .result      (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      in_last_in   = in_last_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (move) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req.data_byte;
         in_last_in  = req.last_byte;
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in = 1'b1;
         result_in    = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      result_ff  <= result_in;
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.byte_value         = result_ff.byte_value;
   assign rsp.byte_role          = result_ff.byte_role;
   assign rsp.option_code        = result_ff.option_code;
   assign rsp.option_length      = result_ff.option_length;
   assign rsp.data_offset        = result_ff.data_offset;
   assign rsp.option_kept        = result_ff.option_kept;
   assign rsp.options_found      = result_ff.options_found;
   assign rsp.message_type       = result_ff.message_type;
   assign rsp.message_type_valid = result_ff.message_type_valid;
   assign rsp.region_done        = result_ff.region_done;
   assign rsp.status             = result_ff.status;

`ifndef SYNTHESIS
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !move |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("stalled input word was lost or overwritten");

   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.region_done |-> !result_ff.status)
      else $error("status raised on a word that does not end a region");

   a_type_zero_until_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.message_type_valid |-> result_ff.message_type == 8'd0)
      else $error("message type shown before it was captured");
`endif

endmodule
